// ----- src/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hgd assertion failed");

// next-cycle implication, disabled while in reset
`define HGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hgd assertion failed");

// next-cycle implication that also runs during reset
`define HGD_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hgd assertion failed");

`endif

// ----- src/hgd_pkg.sv -----
`timescale 1ns / 1ps
package hgd_pkg;

    localparam int CORDIC_STAGES = 24;

    // field widths
    localparam int ANG_W      = 32;
    localparam int DIST_W     = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // internal datapath widths
    localparam int CS_W       = 34;
    localparam int Z_W        = 34;
    localparam int VX_W       = 35;
    localparam int Q60_W      = 61;
    localparam int ROOT_W     = 31;
    localparam int SQRT_W     = 62;
    localparam int SQRT_STEPS = 31;
    localparam int ZC_W       = 31;
    localparam int PROD_W     = 64;

    // register stages ahead of the output register
    localparam int LATENCY = 2 * CORDIC_STAGES + SQRT_STEPS + 6;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [Q60_W-1:0] ONE_Q60      = 61'h1000_0000_0000_0000;
    localparam logic signed [Z_W-1:0] Z_MAX   = 34'sd1073741824;
    localparam logic [32:0] METERS_PER_UNIT   = 33'd5123862220;
    localparam int METERS_SHIFT = 38;
    localparam logic [DIST_W-1:0] MAX_DISTANCE = 25'd20015087;
    localparam logic [DIST_W-1:0] RADIUS_RESET = 25'd100000;

    // arctangent of 2^-k in binary-angle units
    localparam logic [29:0] ATAN_UNITS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LAT = 2'd0,
        CFG_REF_LON = 2'd1,
        CFG_RADIUS  = 2'd2
    } t_cfg_idx;

endpackage

// ----- src/hgd_if.sv -----
`timescale 1ns / 1ps
// position channel
interface hgd_pos_if;
    logic                               valid;
    logic                               ready;
    logic signed [hgd_pkg::ANG_W-1:0]   latitude;
    logic signed [hgd_pkg::ANG_W-1:0]   longitude;
    modport source (output valid, output latitude, output longitude, input ready);
    modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

// result channel
interface hgd_res_if;
    logic                               valid;
    logic                               ready;
    logic [hgd_pkg::DIST_W-1:0]         distance_m;
    logic                               within_res;
    modport source (output valid, output distance_m, output within_res, input ready);
    modport sink   (input valid, input distance_m, input within_res, output ready);
endinterface

// configuration write channel
interface hgd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hgd_pkg::CFG_IDX_W-1:0]      index;
    logic [hgd_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/hgd_sincos.sv -----
`timescale 1ns / 1ps
module hgd_sincos (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [hgd_pkg::ANG_W-1:0]           i_angle,
    output logic signed [hgd_pkg::CS_W-1:0]     o_cos,
    output logic signed [hgd_pkg::CS_W-1:0]     o_sin
);
    localparam int N    = hgd_pkg::CORDIC_STAGES;
    localparam int CS_W = hgd_pkg::CS_W;
    localparam int Z_W  = hgd_pkg::Z_W;

    logic [hgd_pkg::ANG_W-1:0] w_shift;
    logic [hgd_pkg::ANG_W-1:0] w_red;
    logic                      w_flip;

    logic signed [CS_W-1:0] r_x [N];
    logic signed [CS_W-1:0] r_y [N];
    logic signed [Z_W-1:0]  r_z [N-1];
    logic                   r_flip [N];
    logic signed [CS_W-1:0] n_x [N];
    logic signed [CS_W-1:0] n_y [N];
    logic signed [Z_W-1:0]  n_z [N-1];
    logic                   n_flip [N];
    logic signed [CS_W-1:0] r_cos;
    logic signed [CS_W-1:0] r_sin;

    // fold the angle into the right half plane
    assign w_shift = i_angle + hgd_pkg::QUARTER_TURN;
    assign w_flip  = w_shift > hgd_pkg::HALF_TURN;
    assign w_red   = w_flip ? i_angle + hgd_pkg::HALF_TURN : i_angle;

    // one rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_it
        localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(hgd_pkg::ATAN_UNITS[i]);
        logic signed [CS_W-1:0] x_in;
        logic signed [CS_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic                   f_in;
        if (i == 0) begin : g_first
            assign x_in = hgd_pkg::CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = {{(Z_W - hgd_pkg::ANG_W){w_red[hgd_pkg::ANG_W-1]}}, w_red};
            assign f_in = w_flip;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign f_in = r_flip[i-1];
        end
        assign n_x[i]    = z_in[Z_W-1] ? x_in + (y_in >>> i) : x_in - (y_in >>> i);
        assign n_y[i]    = z_in[Z_W-1] ? y_in - (x_in >>> i) : y_in + (x_in >>> i);
        assign n_flip[i] = f_in;
        if (i < N - 1) begin : g_z
            assign n_z[i] = z_in[Z_W-1] ? z_in + ATAN_I : z_in - ATAN_I;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_flip[i] <= n_flip[i];
            end
            for (int i = 0; i < N - 1; i++) begin
                r_z[i] <= n_z[i];
            end
        end
    end

    // undo the fold on the way out
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[N-1] ? -r_x[N-1] : r_x[N-1];
            r_sin <= r_flip[N-1] ? -r_y[N-1] : r_y[N-1];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ----- src/hgd_half_angle.sv -----
`timescale 1ns / 1ps
module hgd_half_angle (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [hgd_pkg::Q60_W-1:0]           i_a,
    output logic signed [hgd_pkg::Z_W-1:0]      o_z
);
    localparam int N      = hgd_pkg::CORDIC_STAGES;
    localparam int STEPS  = hgd_pkg::SQRT_STEPS;
    localparam int SQ_W   = hgd_pkg::SQRT_W;
    localparam int VX_W   = hgd_pkg::VX_W;
    localparam int Z_W    = hgd_pkg::Z_W;
    localparam int ROOT_W = hgd_pkg::ROOT_W;

    logic [hgd_pkg::Q60_W-1:0] w_b;

    // square root lanes: s from a, c from one minus a
    logic [SQ_W-1:0] r_rem_s [STEPS-1];
    logic [SQ_W-1:0] r_rem_c [STEPS-1];
    logic [SQ_W-1:0] r_q_s   [STEPS];
    logic [SQ_W-1:0] r_q_c   [STEPS];
    logic [SQ_W-1:0] n_rem_s [STEPS-1];
    logic [SQ_W-1:0] n_rem_c [STEPS-1];
    logic [SQ_W-1:0] n_q_s   [STEPS];
    logic [SQ_W-1:0] n_q_c   [STEPS];

    // vectoring lanes
    logic signed [VX_W-1:0] r_vx [N-1];
    logic signed [VX_W-1:0] r_vy [N-1];
    logic signed [Z_W-1:0]  r_vz [N];
    logic signed [VX_W-1:0] n_vx [N-1];
    logic signed [VX_W-1:0] n_vy [N-1];
    logic signed [Z_W-1:0]  n_vz [N];

    assign w_b = hgd_pkg::ONE_Q60 - i_a;

    // one result bit per stage, both roots side by side
    for (genvar j = 0; j < STEPS; j++) begin : g_sq
        localparam logic [SQ_W-1:0] BIT_J = SQ_W'(1) << (2 * (STEPS - 1 - j));
        logic [SQ_W-1:0] rs_in;
        logic [SQ_W-1:0] rc_in;
        logic [SQ_W-1:0] qs_in;
        logic [SQ_W-1:0] qc_in;
        logic [SQ_W-1:0] ts;
        logic [SQ_W-1:0] tc;
        logic            ges;
        logic            gec;
        if (j == 0) begin : g_first
            assign rs_in = {1'b0, i_a};
            assign rc_in = {1'b0, w_b};
            assign qs_in = '0;
            assign qc_in = '0;
        end else begin : g_next
            assign rs_in = r_rem_s[j-1];
            assign rc_in = r_rem_c[j-1];
            assign qs_in = r_q_s[j-1];
            assign qc_in = r_q_c[j-1];
        end
        assign ts = qs_in + BIT_J;
        assign tc = qc_in + BIT_J;
        assign ges = rs_in >= ts;
        assign gec = rc_in >= tc;
        assign n_q_s[j] = ges ? (qs_in >> 1) + BIT_J : qs_in >> 1;
        assign n_q_c[j] = gec ? (qc_in >> 1) + BIT_J : qc_in >> 1;
        if (j < STEPS - 1) begin : g_rem
            assign n_rem_s[j] = ges ? rs_in - ts : rs_in;
            assign n_rem_c[j] = gec ? rc_in - tc : rc_in;
        end
    end

    // one vectoring step per stage on (c, s)
    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(hgd_pkg::ATAN_UNITS[i]);
        logic signed [VX_W-1:0] x_in;
        logic signed [VX_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        if (i == 0) begin : g_first
            assign x_in = $signed({4'd0, r_q_c[STEPS-1][ROOT_W-1:0]});
            assign y_in = $signed({4'd0, r_q_s[STEPS-1][ROOT_W-1:0]});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[i-1];
            assign y_in = r_vy[i-1];
            assign z_in = r_vz[i-1];
        end
        assign n_vz[i] = y_in[VX_W-1] ? z_in - ATAN_I : z_in + ATAN_I;
        if (i < N - 1) begin : g_xy
            assign n_vx[i] = y_in[VX_W-1] ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
            assign n_vy[i] = y_in[VX_W-1] ? y_in + (x_in >>> i) : y_in - (x_in >>> i);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STEPS; j++) begin
                r_q_s[j] <= n_q_s[j];
                r_q_c[j] <= n_q_c[j];
            end
            for (int j = 0; j < STEPS - 1; j++) begin
                r_rem_s[j] <= n_rem_s[j];
                r_rem_c[j] <= n_rem_c[j];
            end
            for (int i = 0; i < N; i++) begin
                r_vz[i] <= n_vz[i];
            end
            for (int i = 0; i < N - 1; i++) begin
                r_vx[i] <= n_vx[i];
                r_vy[i] <= n_vy[i];
            end
        end
    end

    assign o_z = r_vz[N-1];

endmodule

// ----- src/haversine_geofence_distance.sv -----
`timescale 1ns / 1ps
// Haversine great-circle distance from each position to a stored reference point.
// i_pos carries latitude and longitude as signed binary angles (full turn = 2^32);
// o_res returns distance_m (whole meters, saturated at half the circumference)
// and within_res, set when the distance is at most the stored radius.
// i_cfg writes the registers: index 0 reference latitude, 1 reference longitude,
// 2 radius in meters; index 3 is ignored. It is always ready; write it only
// while no position is in flight.
// Throughput: one position per cycle while results are taken; a receiver stall
// holds it. The path runs through the sine/cosine CORDIC, the 31-step square root
// and the vectoring CORDIC, each one register stage per iteration.
// Reset (synchronous, active low) empties the pipeline and restores the
// reference point to 0/0 and the radius to 100000 m.
// When the receiver stalls, the whole pipeline holds with the result parked in
// the output register; input ready drops only while that register is full and
// not being taken.
module haversine_geofence_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hgd_pos_if.sink     i_pos,
    hgd_res_if.source   o_res,
    hgd_cfg_if.sink     i_cfg
);
    localparam int LAT  = hgd_pkg::LATENCY;
    localparam int AW   = hgd_pkg::ANG_W;
    localparam int CS_W = hgd_pkg::CS_W;
    localparam int DW   = hgd_pkg::DIST_W;

    logic en;

    // configuration registers
    logic [AW-1:0] r_ref_lat;
    logic [AW-1:0] r_ref_lon;
    logic [DW-1:0] r_radius;

    // valid bits that travel with the data
    logic [LAT-1:0] r_vld;
    logic           r_out_vld;

    // entry stage
    logic [AW-1:0] n_dlat;
    logic [AW-1:0] n_dlon;
    logic [AW-1:0] r_ang_ref;
    logic [AW-1:0] r_ang_lat;
    logic [AW-1:0] r_ang_hlat;
    logic [AW-1:0] r_ang_hlon;

    logic signed [CS_W-1:0] w_c1;
    logic signed [CS_W-1:0] w_c2;
    logic signed [CS_W-1:0] w_u;
    logic signed [CS_W-1:0] w_v;

    // product stages
    logic signed [67:0] n_uu_full;
    logic signed [67:0] n_p_full;
    logic signed [67:0] n_w_full;
    logic signed [67:0] n_pw_full;
    logic signed [63:0] r_uu;
    logic signed [CS_W-1:0] r_p;
    logic signed [CS_W-1:0] r_w;
    logic signed [63:0] r_uu2;
    logic signed [63:0] r_pw;
    logic signed [64:0] n_sum;
    logic [hgd_pkg::Q60_W-1:0] n_a;
    logic [hgd_pkg::Q60_W-1:0] r_a;

    logic signed [hgd_pkg::Z_W-1:0] w_z;
    logic [hgd_pkg::ZC_W-1:0] n_zc;
    logic [hgd_pkg::PROD_W-1:0] n_prod;
    logic [hgd_pkg::PROD_W-1:0] r_prod;

    logic [hgd_pkg::PROD_W-1:0] n_round;
    logic [hgd_pkg::PROD_W-hgd_pkg::METERS_SHIFT-1:0] n_dist_raw;
    logic [DW-1:0] n_dist;
    logic [DW-1:0] r_dist;
    logic          r_within;

    // pipeline advances unless a finished result is stuck
    assign en          = !r_out_vld || o_res.ready;
    assign i_pos.ready = en;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat <= '0;
            r_ref_lon <= '0;
            r_radius  <= hgd_pkg::RADIUS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hgd_pkg::CFG_REF_LAT: r_ref_lat <= i_cfg.data;
                hgd_pkg::CFG_REF_LON: r_ref_lon <= i_cfg.data;
                hgd_pkg::CFG_RADIUS:  r_radius  <= i_cfg.data[DW-1:0];
                default: ;
            endcase
        end
    end

    // valid shift line and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[LAT-2:0], i_pos.valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    // wrapped half differences
    assign n_dlat = i_pos.latitude - r_ref_lat;
    assign n_dlon = i_pos.longitude - r_ref_lon;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_ref  <= r_ref_lat;
            r_ang_lat  <= i_pos.latitude;
            r_ang_hlat <= {n_dlat[AW-1], n_dlat[AW-1:1]};
            r_ang_hlon <= {n_dlon[AW-1], n_dlon[AW-1:1]};
        end
    end

    // four sine/cosine pipelines
    hgd_sincos u_sc_ref (
        .i_clk(i_clk), .i_en(en), .i_angle(r_ang_ref), .o_cos(w_c1), .o_sin()
    );
    hgd_sincos u_sc_lat (
        .i_clk(i_clk), .i_en(en), .i_angle(r_ang_lat), .o_cos(w_c2), .o_sin()
    );
    hgd_sincos u_sc_hlat (
        .i_clk(i_clk), .i_en(en), .i_angle(r_ang_hlat), .o_cos(), .o_sin(w_u)
    );
    hgd_sincos u_sc_hlon (
        .i_clk(i_clk), .i_en(en), .i_angle(r_ang_hlon), .o_cos(), .o_sin(w_v)
    );

    // first products
    assign n_uu_full = w_u * w_u;
    assign n_p_full  = w_c1 * w_c2;
    assign n_w_full  = w_v * w_v;
    // second product
    assign n_pw_full = r_p * r_w;

    // haversine term, clamped to [0, 1]
    always_comb begin
        n_sum = $signed({r_uu2[63], r_uu2}) + $signed({r_pw[63], r_pw});
        if (n_sum[64]) begin
            n_a = '0;
        end else if (n_sum[63:0] > {3'd0, hgd_pkg::ONE_Q60}) begin
            n_a = hgd_pkg::ONE_Q60;
        end else begin
            n_a = n_sum[hgd_pkg::Q60_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_uu  <= n_uu_full[63:0];
            r_p   <= n_p_full[63:30];
            r_w   <= n_w_full[63:30];
            r_uu2 <= r_uu;
            r_pw  <= n_pw_full[63:0];
            r_a   <= n_a;
        end
    end

    // square roots and arctangent
    hgd_half_angle u_half_angle (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .o_z(w_z)
    );

    // clamp half angle and scale to meters
    always_comb begin
        if (w_z[hgd_pkg::Z_W-1]) begin
            n_zc = '0;
        end else if (w_z > hgd_pkg::Z_MAX) begin
            n_zc = hgd_pkg::Z_MAX[hgd_pkg::ZC_W-1:0];
        end else begin
            n_zc = w_z[hgd_pkg::ZC_W-1:0];
        end
        n_prod = {33'd0, n_zc} * {31'd0, hgd_pkg::METERS_PER_UNIT};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= n_prod;
        end
    end

    // round, saturate, compare
    always_comb begin
        n_round    = r_prod + (64'd1 << (hgd_pkg::METERS_SHIFT - 1));
        n_dist_raw = n_round[hgd_pkg::PROD_W-1:hgd_pkg::METERS_SHIFT];
        if (n_dist_raw > {1'b0, hgd_pkg::MAX_DISTANCE}) begin
            n_dist = hgd_pkg::MAX_DISTANCE;
        end else begin
            n_dist = n_dist_raw[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist   <= n_dist;
            r_within <= n_dist <= r_radius;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.distance_m = r_dist;
    assign o_res.within_res = r_within;

endmodule

// ----- src/hgd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hgd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hgd_pkg::DIST_W-1:0]   i_distance_m,
    input logic                         i_within_res
);
    // a stalled result stays put
    `HGD_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_distance_m) && $stable(i_within_res))
    // distance never exceeds half the circumference
    `HGD_ASSERT_IMP(a_dist_range, i_clk, i_rst_n, i_out_valid, i_distance_m <= hgd_pkg::MAX_DISTANCE)
    // an empty output register never holds back the input
    `HGD_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    // reset empties the output
    `HGD_ASSERT_ALW(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind haversine_geofence_distance hgd_checker u_hgd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pos.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_distance_m (o_res.distance_m),
    .i_within_res (o_res.within_res)
);
